[sv/cpgts_pkg.sv]
// Shared types and constants of the cascaded probe grid trilinear sampler.
// Holds the register indexes and the command and status groups between
// controller and datapath; depends on nothing.
`timescale 1ns / 1ps
package cpgts_pkg;

  localparam int MAX_LEVELS_DEF  = 4;
  localparam int CHUNK_SIZE_DEF  = 32;
  localparam int MAX_PROBES_DEF  = 17;

  localparam int COLOR_W     = 16;
  localparam int POS_W       = 16;
  localparam int LEVEL_W     = 2;
  localparam int INDEX_W     = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int LCOUNT_W    = 3;
  localparam int SPACING_W   = 2;
  localparam int FRAC_BASE   = 8;
  localparam int SPACING_MAX = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_COUNT   = 3'd0,
    REG_SPACING_LOG2  = 3'd1,
    REG_AMBIENT_RED   = 3'd2,
    REG_AMBIENT_GREEN = 3'd3,
    REG_AMBIENT_BLUE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic write;
    logic load;
    logic setup_a;
    logic setup_b;
    logic setup_c;
    logic read;
    logic lerp;
    logic accum;
    logic div_init;
    logic div_step;
    logic emit_ambient;
    logic emit_quot;
  } cmd_t;

  typedef struct packed {
    logic k_zero;
    logic last_corner;
    logic last_step;
    logic last_level;
    logic div_last;
  } status_t;

endpackage

[sv/cpgts_ctrl.sv]
// Sequencer of the sampler: a one-hot state machine that steps the datapath
// through levels, corner reads, lerps, the blend divide and the result.
// Depends on cpgts_pkg.
`timescale 1ns / 1ps
module cpgts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               func,
  input  cpgts_pkg::status_t status,
  output cpgts_pkg::cmd_t    cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_SETUP_A  = 12'b000000000010,
    S_SETUP_B  = 12'b000000000100,
    S_SETUP_C  = 12'b000000001000,
    S_READ     = 12'b000000010000,
    S_WAIT     = 12'b000000100000,
    S_LERP     = 12'b000001000000,
    S_ACCUM    = 12'b000010000000,
    S_DIV_INIT = 12'b000100000000,
    S_DIV      = 12'b001000000000,
    S_FINISH   = 12'b010000000000,
    S_AMBIENT  = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.write = start & ~func;
        cmd.load  = start & func;
        if (start && func) begin
          state_next = status.k_zero ? S_AMBIENT : S_SETUP_A;
        end
      end
      S_SETUP_A: begin
        cmd.setup_a = 1'b1;
        state_next = S_SETUP_B;
      end
      S_SETUP_B: begin
        cmd.setup_b = 1'b1;
        state_next = S_SETUP_C;
      end
      S_SETUP_C: begin
        cmd.setup_c = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read = 1'b1;
        if (status.last_corner) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_LERP;
      end
      S_LERP: begin
        cmd.lerp = 1'b1;
        if (status.last_step) begin
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        state_next = status.last_level ? S_DIV_INIT : S_SETUP_A;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.emit_quot = 1'b1;
        state_next = S_IDLE;
      end
      S_AMBIENT: begin
        cmd.emit_ambient = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.emit_ambient | cmd.emit_quot;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

[sv/cpgts_datapath.sv]
// Datapath of the sampler: configuration registers, the probe memory, level
// setup, the corner queue with its lerp lanes, the accumulators and the
// blend divider. Depends on cpgts_pkg.
`timescale 1ns / 1ps
module cpgts_datapath #(
  parameter int MAX_LEVELS          = cpgts_pkg::MAX_LEVELS_DEF,
  parameter int CHUNK_SIZE          = cpgts_pkg::CHUNK_SIZE_DEF,
  parameter int MAX_PROBES_PER_AXIS = cpgts_pkg::MAX_PROBES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cpgts_pkg::cmd_t                        cmd,
  output cpgts_pkg::status_t                     status,
  input  logic                                   cfg_we,
  input  logic [cpgts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cpgts_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [cpgts_pkg::LEVEL_W-1:0]          level,
  input  logic [cpgts_pkg::INDEX_W-1:0]          probe_index,
  input  logic [cpgts_pkg::COLOR_W-1:0]          probe_red,
  input  logic [cpgts_pkg::COLOR_W-1:0]          probe_green,
  input  logic [cpgts_pkg::COLOR_W-1:0]          probe_blue,
  input  logic signed [cpgts_pkg::POS_W-1:0]     pos_x,
  input  logic signed [cpgts_pkg::POS_W-1:0]     pos_y,
  input  logic signed [cpgts_pkg::POS_W-1:0]     pos_z,
  output logic [cpgts_pkg::COLOR_W-1:0]          out_red,
  output logic [cpgts_pkg::COLOR_W-1:0]          out_green,
  output logic [cpgts_pkg::COLOR_W-1:0]          out_blue
);

  localparam int CLW   = cpgts_pkg::COLOR_W;
  localparam int LD    = MAX_PROBES_PER_AXIS * MAX_PROBES_PER_AXIS * MAX_PROBES_PER_AXIS;
  localparam int DEPTH = MAX_LEVELS * LD;
  localparam int AW    = $clog2(DEPTH);
  localparam int LVW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int KW    = $clog2(MAX_LEVELS + 1);
  localparam int SW    = $clog2(cpgts_pkg::SPACING_MAX + MAX_LEVELS);
  localparam int FMAX  = cpgts_pkg::FRAC_BASE + cpgts_pkg::SPACING_MAX + MAX_LEVELS - 1;
  localparam int FW    = $clog2(FMAX + 1);
  localparam int TW    = FMAX;
  localparam int PW    = (TW > cpgts_pkg::POS_W) ? TW : cpgts_pkg::POS_W;
  localparam int CW    = $clog2(MAX_PROBES_PER_AXIS);
  localparam int NW    = $clog2(MAX_PROBES_PER_AXIS + 1);
  localparam int ACCW  = CLW + MAX_LEVELS;
  localparam int DCW   = $clog2(ACCW);
  localparam int RW    = MAX_LEVELS + 1;
  localparam int PRW   = CLW + TW + 2;
  localparam int WW    = 3 * CLW;

  // Configuration registers.
  logic [cpgts_pkg::LCOUNT_W-1:0]  level_count;
  logic [cpgts_pkg::SPACING_W-1:0] spacing_log2;
  logic [CLW-1:0]                  ambient [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count  <= '0;
      spacing_log2 <= cpgts_pkg::SPACING_W'(1);
      ambient[0]   <= '0;
      ambient[1]   <= '0;
      ambient[2]   <= '0;
    end else if (cfg_we) begin
      case (cpgts_pkg::cfg_reg_t'(cfg_index))
        cpgts_pkg::REG_LEVEL_COUNT:   level_count  <= cfg_data[cpgts_pkg::LCOUNT_W-1:0];
        cpgts_pkg::REG_SPACING_LOG2:  spacing_log2 <= cfg_data[cpgts_pkg::SPACING_W-1:0];
        cpgts_pkg::REG_AMBIENT_RED:   ambient[0]   <= cfg_data[CLW-1:0];
        cpgts_pkg::REG_AMBIENT_GREEN: ambient[1]   <= cfg_data[CLW-1:0];
        cpgts_pkg::REG_AMBIENT_BLUE:  ambient[2]   <= cfg_data[CLW-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [KW-1:0]                   k;
  logic [cpgts_pkg::SPACING_W-1:0] base;

  assign k    = (int'(level_count) > MAX_LEVELS) ? KW'(MAX_LEVELS) : KW'(level_count);
  assign base = (spacing_log2 == '0) ? cpgts_pkg::SPACING_W'(1) : spacing_log2;

  // Sequencing counters.
  logic [LVW-1:0] lvl;
  logic [2:0]     cnt;
  logic [DCW-1:0] dcnt;
  logic           cap_pipe;

  assign status.k_zero      = (k == '0);
  assign status.last_corner = (cnt == 3'd7);
  assign status.last_step   = (cnt == 3'd6);
  assign status.last_level  = (int'(lvl) == int'(k) - 1);
  assign status.div_last    = (dcnt == DCW'(ACCW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl      <= '0;
      cnt      <= '0;
      dcnt     <= '0;
      cap_pipe <= 1'b0;
    end else begin
      cap_pipe <= cmd.read;
      if (cmd.load) begin
        lvl <= '0;
      end else if (cmd.accum) begin
        lvl <= lvl + LVW'(1);
      end
      if (cmd.setup_a) begin
        cnt <= '0;
      end else if (cmd.read || cmd.lerp) begin
        cnt <= cnt + 3'd1;
      end
      if (cmd.div_init) begin
        dcnt <= '0;
      end else if (cmd.div_step) begin
        dcnt <= dcnt + DCW'(1);
      end
    end
  end

  // Sample position.
  logic signed [cpgts_pkg::POS_W-1:0] pos [3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos[0] <= pos_x;
      pos[1] <= pos_y;
      pos[2] <= pos_z;
    end
  end

  // Level setup: axis count, clamped corner coordinates and weights.
  logic [SW-1:0]   s_cur;
  logic [FW-1:0]   f_cur;
  logic [NW-1:0]   n_cur;
  logic [CW-1:0]   lo_cur [3];
  logic [CW-1:0]   hi_cur [3];
  logic [TW-1:0]   t_cur [3];
  logic [FW-1:0]   f_reg;
  logic [NW-1:0]   n_reg;
  logic [CW-1:0]   lo_c [3];
  logic [CW-1:0]   hi_c [3];
  logic [TW-1:0]   t_c [3];

  always_comb begin
    int nr;
    int qi;
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] q;
    s_cur = SW'(base) + SW'(lvl);
    f_cur = FW'(cpgts_pkg::FRAC_BASE) + FW'(s_cur);
    nr = ((CHUNK_SIZE - 1) >> s_cur) + 2;
    if (nr > MAX_PROBES_PER_AXIS) begin
      nr = MAX_PROBES_PER_AXIS;
    end
    n_cur = NW'(nr);
    for (int a = 0; a < 3; a++) begin
      px = PW'(pos[a]);
      q = px >>> f_cur;
      qi = int'(q);
      t_cur[a] = px[TW-1:0] & ~({TW{1'b1}} << f_cur);
      if (qi < 0) begin
        lo_cur[a] = '0;
      end else if (qi > nr - 1) begin
        lo_cur[a] = CW'(nr - 1);
      end else begin
        lo_cur[a] = CW'(qi);
      end
      if (qi + 1 < 0) begin
        hi_cur[a] = '0;
      end else if (qi + 1 > nr - 1) begin
        hi_cur[a] = CW'(nr - 1);
      end else begin
        hi_cur[a] = CW'(qi + 1);
      end
    end
  end

  logic [AW-1:0] nn;
  logic [AW-1:0] yoff_lo, yoff_hi, zoff_lo, zoff_hi, lvl_base;

  always_ff @(posedge clk) begin
    if (cmd.setup_a) begin
      f_reg <= f_cur;
      n_reg <= n_cur;
      for (int a = 0; a < 3; a++) begin
        lo_c[a] <= lo_cur[a];
        hi_c[a] <= hi_cur[a];
        t_c[a]  <= t_cur[a];
      end
    end
    if (cmd.setup_b) begin
      nn       <= AW'(n_reg) * AW'(n_reg);
      yoff_lo  <= AW'(lo_c[1]) * AW'(n_reg);
      yoff_hi  <= AW'(hi_c[1]) * AW'(n_reg);
      lvl_base <= AW'(lvl) * AW'(LD);
    end
    if (cmd.setup_c) begin
      zoff_lo <= AW'(lo_c[2]) * nn;
      zoff_hi <= AW'(hi_c[2]) * nn;
    end
  end

  // Probe memory.
  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          wen;

  assign wen   = cmd.write && (int'(level) < MAX_LEVELS) && (int'(probe_index) < LD);
  assign waddr = AW'(level) * AW'(LD) + AW'(probe_index);
  assign raddr = lvl_base
               + AW'(cnt[0] ? hi_c[0] : lo_c[0])
               + (cnt[1] ? yoff_hi : yoff_lo)
               + (cnt[2] ? zoff_hi : zoff_lo);

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= {probe_blue, probe_green, probe_red};
    end
    rdata <= mem[raddr];
  end

  // Corner queue: reads shift in at the tail; each lerp takes the two head
  // entries and writes its result behind the entries still waiting.
  logic [WW-1:0] v [8];
  logic [WW-1:0] lerp_r;
  logic [TW-1:0] tsel;
  logic [2:0]    widx;

  assign tsel = (cnt < 3'd4) ? t_c[0] : ((cnt < 3'd6) ? t_c[1] : t_c[2]);
  assign widx = 3'd6 - cnt;

  always_comb begin
    logic [CLW-1:0]        ca;
    logic [CLW-1:0]        cb;
    logic signed [PRW-1:0] diff;
    logic signed [PRW-1:0] tw;
    logic signed [PRW-1:0] prod;
    logic signed [PRW-1:0] sh;
    tw = PRW'(signed'({1'b0, tsel}));
    for (int j = 0; j < 3; j++) begin
      ca = v[0][j*CLW +: CLW];
      cb = v[1][j*CLW +: CLW];
      diff = PRW'(signed'({1'b0, cb})) - PRW'(signed'({1'b0, ca}));
      prod = diff * tw;
      sh = prod >>> f_reg;
      lerp_r[j*CLW +: CLW] = ca + sh[CLW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cap_pipe) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i+1];
      end
      v[7] <= rdata;
    end else if (cmd.lerp) begin
      for (int i = 0; i < 6; i++) begin
        v[i] <= v[i+2];
      end
      v[widx] <= lerp_r;
    end
  end

  // Weighted accumulation and the blend divide by 2^k - 1.
  logic [ACCW-1:0]       acc [3];
  logic [ACCW-1:0]       quo [3];
  logic [RW-1:0]         rem [3];
  logic [MAX_LEVELS-1:0] dvs;

  assign dvs = MAX_LEVELS'((1 << k) - 1);

  always_ff @(posedge clk) begin
    int sh;
    logic [RW-1:0] rsh;
    sh = int'(k) - 1 - int'(lvl);
    for (int j = 0; j < 3; j++) begin
      if (cmd.load) begin
        acc[j] <= '0;
      end else if (cmd.accum) begin
        acc[j] <= acc[j] + (ACCW'(v[0][j*CLW +: CLW]) << sh);
      end
      rsh = {rem[j][RW-2:0], quo[j][ACCW-1]};
      if (cmd.div_init) begin
        quo[j] <= acc[j];
        rem[j] <= '0;
      end else if (cmd.div_step) begin
        if (rsh >= {1'b0, dvs}) begin
          rem[j] <= rsh - {1'b0, dvs};
          quo[j] <= {quo[j][ACCW-2:0], 1'b1};
        end else begin
          rem[j] <= rsh;
          quo[j] <= {quo[j][ACCW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ambient) begin
      out_red   <= ambient[0];
      out_green <= ambient[1];
      out_blue  <= ambient[2];
    end else if (cmd.emit_quot) begin
      out_red   <= quo[0][CLW-1:0];
      out_green <= quo[1][CLW-1:0];
      out_blue  <= quo[2][CLW-1:0];
    end
  end

endmodule

[sv/cascaded_probe_grid_trilinear_sampler.sv]
// Top level of the cascaded probe grid trilinear sampler.
// Instantiates cpgts_ctrl and cpgts_datapath; depends on cpgts_pkg.
//
// A request is taken when start is high and busy is low. A write request
// (func low) stores its probe colour in that same cycle and leaves busy low,
// so writes may follow each other on every cycle. A sample request (func
// high) raises busy and runs one level at a time through the single probe
// memory read port: three setup steps, eight corner reads, a wait for the
// registered read data, seven lerp steps and one accumulate. A blend
// divide with one restoring step per accumulator bit, between an init and a
// finish step, follows the last level; the result appears in the first cycle
// with busy low again. With no levels busy is high for one cycle. The result
// appears on out_red, out_green and out_blue for exactly one cycle, marked by
// done, and is not held: the receiver must take it in that cycle.
// Configuration writes are taken at any time but must only change registers
// while the block is idle.
`timescale 1ns / 1ps
module cascaded_probe_grid_trilinear_sampler #(
  parameter int MAX_LEVELS          = cpgts_pkg::MAX_LEVELS_DEF,
  parameter int CHUNK_SIZE          = cpgts_pkg::CHUNK_SIZE_DEF,
  parameter int MAX_PROBES_PER_AXIS = cpgts_pkg::MAX_PROBES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  output logic                               done,
  input  logic                               cfg_we,
  input  logic [cpgts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpgts_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               func,
  input  logic [cpgts_pkg::LEVEL_W-1:0]      level,
  input  logic [cpgts_pkg::INDEX_W-1:0]      probe_index,
  input  logic [cpgts_pkg::COLOR_W-1:0]      probe_red,
  input  logic [cpgts_pkg::COLOR_W-1:0]      probe_green,
  input  logic [cpgts_pkg::COLOR_W-1:0]      probe_blue,
  input  logic signed [cpgts_pkg::POS_W-1:0] pos_x,
  input  logic signed [cpgts_pkg::POS_W-1:0] pos_y,
  input  logic signed [cpgts_pkg::POS_W-1:0] pos_z,
  output logic [cpgts_pkg::COLOR_W-1:0]      out_red,
  output logic [cpgts_pkg::COLOR_W-1:0]      out_green,
  output logic [cpgts_pkg::COLOR_W-1:0]      out_blue
);

  cpgts_pkg::cmd_t    cmd;
  cpgts_pkg::status_t status;

  cpgts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  cpgts_datapath #(
    .MAX_LEVELS          (MAX_LEVELS),
    .CHUNK_SIZE          (CHUNK_SIZE),
    .MAX_PROBES_PER_AXIS (MAX_PROBES_PER_AXIS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .level       (level),
    .probe_index (probe_index),
    .probe_red   (probe_red),
    .probe_green (probe_green),
    .probe_blue  (probe_blue),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

endmodule

[sim/tb_cascaded_probe_grid_trilinear_sampler.sv]
// Self-checking testbench for cascaded_probe_grid_trilinear_sampler.
// Fills every probe a sample can read, then runs directed and random requests
// against a built-in predictor of the sampler; depends on cpgts_pkg and the block.
`timescale 1ns / 1ps
module tb_cascaded_probe_grid_trilinear_sampler;

  localparam int LEVEL_DEPTH = 17 * 17 * 17;
  localparam int STORE_DEPTH = 4 * LEVEL_DEPTH;

  typedef struct packed {
    logic        is_sample;
    logic [1:0]  lvl;
    logic [12:0] idx;
    logic [47:0] rgb;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic cfg_we = 1'b0;
  logic [cpgts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cpgts_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic func = 1'b0;
  logic [cpgts_pkg::LEVEL_W-1:0] level = '0;
  logic [cpgts_pkg::INDEX_W-1:0] probe_index = '0;
  logic [cpgts_pkg::COLOR_W-1:0] probe_red = '0, probe_green = '0, probe_blue = '0;
  logic signed [cpgts_pkg::POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [cpgts_pkg::COLOR_W-1:0] out_red, out_green, out_blue;

  logic [47:0] probe_mem [0:STORE_DEPTH-1];
  logic [47:0] color_queue [$];
  int unsigned levels_reg = 0;
  int unsigned spacing_reg = 1;
  logic [47:0] ambient_reg = '0;
  int mismatches = 0;
  bit steady = 1'b0;

  cascaded_probe_grid_trilinear_sampler dut (.*);

  always #4 clk = ~clk;

  function automatic int axis_len(int s);
    int sp;
    int n;
    sp = 1 << s;
    n = (32 + sp - 1) / sp + 1;
    if (n < 2) n = 2;
    if (n > 17) n = 17;
    return n;
  endfunction

  function automatic int clamp_coord(longint c, int n);
    if (c < 0) return 0;
    if (c > n - 1) return n - 1;
    return int'(c);
  endfunction

  // Positions driven here only reach the three lowest and the last probe of an axis.
  function automatic bit probe_needed(int c, int n);
    return (c <= 2) || (c == n - 1);
  endfunction

  function automatic longint unsigned lerp(longint unsigned a, longint unsigned b,
                                           longint unsigned t, int f);
    return (a * ((64'd1 << f) - t) + b * t) >> f;
  endfunction

  function automatic logic [47:0] level_color(int lvl, int s, logic [15:0] px,
                                              logic [15:0] py, logic [15:0] pz);
    int f;
    int n;
    int lo[3];
    int hi[3];
    longint unsigned t[3];
    longint u;
    longint q;
    logic [15:0] p[3];
    logic [47:0] corner[8];
    longint unsigned ch[8];
    longint unsigned x00, x10, x01, x11, y0, y1;
    logic [47:0] res;
    int addr;
    f = 8 + s;
    n = axis_len(s);
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    res = '0;
    for (int a = 0; a < 3; a++) begin
      u = longint'($signed(p[a])) + 1048576;
      q = (u >>> f) - (1048576 >> f);
      t[a] = u & ((64'd1 << f) - 1);
      lo[a] = clamp_coord(q, n);
      hi[a] = clamp_coord(q + 1, n);
    end
    for (int c = 0; c < 8; c++) begin
      addr = lvl * LEVEL_DEPTH + (c[0] ? hi[0] : lo[0]) + (c[1] ? hi[1] : lo[1]) * n
             + (c[2] ? hi[2] : lo[2]) * n * n;
      corner[c] = probe_mem[addr];
    end
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 8; c++) ch[c] = (corner[c] >> (32 - 16 * a)) & 48'hFFFF;
      x00 = lerp(ch[0], ch[1], t[0], f);
      x10 = lerp(ch[2], ch[3], t[0], f);
      x01 = lerp(ch[4], ch[5], t[0], f);
      x11 = lerp(ch[6], ch[7], t[0], f);
      y0 = lerp(x00, x10, t[1], f);
      y1 = lerp(x01, x11, t[1], f);
      res[47 - 16 * a -: 16] = 16'(lerp(y0, y1, t[2], f));
    end
    return res;
  endfunction

  function automatic logic [47:0] blended_color(request_t r);
    int k;
    int base;
    longint unsigned acc[3];
    logic [47:0] lc;
    logic [47:0] res;
    k = (levels_reg > 4) ? 4 : levels_reg;
    base = (spacing_reg == 0) ? 1 : spacing_reg;
    if (k == 0) return ambient_reg;
    for (int a = 0; a < 3; a++) acc[a] = 0;
    for (int l = 0; l < k; l++) begin
      lc = level_color(l, base + l, r.px, r.py, r.pz);
      for (int a = 0; a < 3; a++)
        acc[a] += longint'(lc[47 - 16 * a -: 16]) << (k - 1 - l);
    end
    for (int a = 0; a < 3; a++)
      res[47 - 16 * a -: 16] = 16'(acc[a] / ((64'd1 << k) - 1));
    return res;
  endfunction

  task automatic send(request_t r);
    if (!steady && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    func <= r.is_sample;
    level <= r.lvl;
    probe_index <= r.idx;
    {probe_red, probe_green, probe_blue} <= r.rgb;
    pos_x <= r.px;
    pos_y <= r.py;
    pos_z <= r.pz;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (r.is_sample) color_queue = {color_queue, blended_color(r)};
    else if (r.idx < LEVEL_DEPTH) probe_mem[r.lvl * LEVEL_DEPTH + r.idx] = r.rgb;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (color_queue.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cpgts_pkg::cfg_reg_t idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      cpgts_pkg::REG_LEVEL_COUNT:   levels_reg = value & 7;
      cpgts_pkg::REG_SPACING_LOG2:  spacing_reg = value & 3;
      cpgts_pkg::REG_AMBIENT_RED:   ambient_reg[47:32] = value;
      cpgts_pkg::REG_AMBIENT_GREEN: ambient_reg[31:16] = value;
      cpgts_pkg::REG_AMBIENT_BLUE:  ambient_reg[15:0] = value;
      default: ;
    endcase
  endtask

  task automatic set_config(int lc, int sp, logic [47:0] amb);
    drain();
    write_reg(cpgts_pkg::REG_LEVEL_COUNT, 16'(lc));
    write_reg(cpgts_pkg::REG_SPACING_LOG2, 16'(sp));
    write_reg(cpgts_pkg::REG_AMBIENT_RED, amb[47:32]);
    write_reg(cpgts_pkg::REG_AMBIENT_GREEN, amb[31:16]);
    write_reg(cpgts_pkg::REG_AMBIENT_BLUE, amb[15:0]);
  endtask

  function automatic logic [47:0] random_rgb();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return 48'({$urandom(), $urandom()});
    endcase
  endfunction

  // Negative, near the origin, or far enough out to clamp to the last probe.
  function automatic logic [15:0] random_pos();
    case ($urandom_range(0, 3))
      0: return 16'h8000 | 16'($urandom_range(0, 32767));
      1: return 16'h4000 | 16'($urandom_range(0, 16383));
      default: return 16'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic request_t write_req(int lvl, int idx, logic [47:0] rgb);
    request_t r;
    r = {1'b0, 2'(lvl), 13'(idx), rgb, 16'($urandom()), 16'($urandom()), 16'($urandom())};
    return r;
  endfunction

  function automatic request_t sample_req(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    request_t r;
    r = {1'b1, 2'($urandom()), 13'($urandom()), 48'({$urandom(), $urandom()}), px, py, pz};
    return r;
  endfunction

  // Every entry that the driven positions can reach at any legal spacing gets a value.
  task automatic test_fill();
    int n;
    steady = 1'b1;
    for (int l = 0; l < 4; l++) begin
      for (int s = l + 1; s <= l + 3; s++) begin
        n = axis_len(s);
        for (int z = 0; z < n; z++) begin
          for (int y = 0; y < n; y++) begin
            for (int x = 0; x < n; x++) begin
              if (probe_needed(x, n) && probe_needed(y, n) && probe_needed(z, n))
                send(write_req(l, x + y * n + z * n * n, random_rgb()));
            end
          end
        end
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_directed_writes();
    send(write_req(0, 0, '1));
    send(write_req(3, 26, '0));
    send(write_req(1, LEVEL_DEPTH, '1));
    send(write_req(2, 8191, '1));
    send(write_req(0, 4912, {16'hFFFF, 16'h0000, 16'h8001}));
  endtask

  task automatic test_directed_samples();
    set_config(0, 1, {16'hFFFF, 16'h0000, 16'h1234});
    send(sample_req(16'h0000, 16'h7FFF, 16'h8000));
    set_config(4, 1, '0);
    send(sample_req(16'h0000, 16'h0000, 16'h0000));
    send(sample_req(16'h8000, 16'h8000, 16'h8000));
    send(sample_req(16'h7FFF, 16'h7FFF, 16'h7FFF));
    send(sample_req(16'hFFFF, 16'h0100, 16'h2000));
    send(sample_req(16'h0180, 16'h0380, 16'h03FF));
    set_config(7, 3, '1);
    send(sample_req(16'h0440, 16'h4010, 16'h00FF));
    send(sample_req(16'h8000, 16'h7FFF, 16'h0000));
    set_config(1, 0, '0);
    send(sample_req(16'h0123, 16'h0356, 16'h0389));
    set_config(2, 2, '0);
    send(sample_req(16'h0200, 16'h5000, 16'hFF00));
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_config(4, 1, random_rgb());
        1: set_config(0, $urandom_range(0, 3), random_rgb());
        2: set_config(7, 3, '1);
        3: set_config(1, 0, '0);
        default: set_config($urandom_range(0, 7), $urandom_range(0, 3), random_rgb());
      endcase
      steady = (ph == 2);
      for (int i = 0; i < 155; i++) begin
        if ($urandom_range(0, 99) < 60)
          send(sample_req(random_pos(), random_pos(), random_pos()));
        else
          send(write_req($urandom_range(0, 3), $urandom_range(0, 8191), random_rgb()));
      end
    end
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst && done) begin
      if (color_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h", out_red, out_green,
                                       out_blue);
      end else begin
        logic [47:0] want;
        want = color_queue.pop_front();
        if ({out_red, out_green, out_blue} !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h, got %h %h %h", want[47:32], want[31:16],
                     want[15:0], out_red, out_green, out_blue);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill();
    test_directed_writes();
    test_directed_samples();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("tb_cascaded_probe_grid_trilinear_sampler: PASS");
    else $display("tb_cascaded_probe_grid_trilinear_sampler: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_cascaded_probe_grid_trilinear_sampler: FAIL");
    $finish;
  end

endmodule
